[rtl/scc_pkg.sv]
// Shared types, constants and scaling helper for the stick command conditioner.
`default_nettype none
package scc_pkg;

    localparam int RawW  = 12;
    localparam int CmdW  = 10;
    localparam int TimeW = 32;

    localparam logic [RawW-1:0]  CenterReset  = 12'd2048;
    localparam logic [RawW-1:0]  Deadband     = 12'd40;
    localparam logic [RawW-1:0]  AxisSpan     = 12'd1800;
    localparam logic [RawW-1:0]  ThrSpan      = 12'd3600;
    localparam logic [RawW:0]    ThrCut       = 13'd120;
    localparam logic [RawW:0]    GestureRaw   = 13'd900;
    localparam logic [TimeW-1:0] ToggleLockMs = 32'd250;
    localparam logic [TimeW-1:0] GraceMs      = 32'd300;
    localparam logic [TimeW-1:0] HoldMs       = 32'd3000;
    localparam logic [TimeW-1:0] SendMs       = 32'd20;

    // 5/18 as a fixed-point reciprocal with 16 fraction bits, exact for inputs up to 3600
    localparam logic [14:0] Recip5Over18 = 15'd18205;

    // configuration register indexes
    localparam logic [1:0] RegThrCenter   = 2'd0;
    localparam logic [1:0] RegYawCenter   = 2'd1;
    localparam logic [1:0] RegPitchCenter = 2'd2;
    localparam logic [1:0] RegRollCenter  = 2'd3;

    localparam int InDataW  = 88;
    localparam int OutDataW = 48;

    typedef struct packed {
        logic armed;
        logic grace;
        logic cal;
        logic send;
    } t_mode_status;

    typedef struct packed {
        logic [RawW-1:0] thr;
        logic [RawW-1:0] yaw;
        logic [RawW-1:0] pitch;
        logic [RawW-1:0] roll;
    } t_sticks;

    // floor(m * 5 / 18); 3600 maps to 1000, so the top bits stay clear
    function automatic logic [CmdW-1:0] scale_5_18(input logic [RawW-1:0] m);
        logic [RawW+13:0] p;
        p = m * Recip5Over18;
        return p[RawW+13:16];
    endfunction

endpackage
`default_nettype wire

[rtl/scc_mode.sv]
// Arming, grace window, calibration gesture hold and send timer state.
`default_nettype none
module scc_mode (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  wire [scc_pkg::TimeW-1:0]     i_now,
    input  wire                          i_left,
    input  wire                          i_right,
    input  scc_pkg::t_sticks             i_raw,
    input  scc_pkg::t_sticks             i_center,
    output scc_pkg::t_mode_status        o_status
);

    logic                        r_prev_left, r_prev_right, r_armed, r_hold_fired;
    logic [scc_pkg::TimeW-1:0]   r_toggle_time, r_grace_end, r_hold_start, r_send_time;

    logic                        n_armed, n_hold_fired;
    logic [scc_pkg::TimeW-1:0]   n_toggle_time, n_grace_end, n_hold_start, n_send_time;

    logic                        press, toggle, gesture, send;
    logic [scc_pkg::TimeW-1:0]   hs_eff;
    logic                        hf_eff;

    always_comb begin
        press  = (r_prev_left && !i_left) || (r_prev_right && !i_right);
        toggle = press && ((i_now - r_toggle_time) > scc_pkg::ToggleLockMs);

        n_armed       = r_armed ^ toggle;
        n_toggle_time = toggle ? i_now : r_toggle_time;
        n_grace_end   = r_grace_end;
        if (toggle) begin
            n_grace_end = n_armed ? i_now + scc_pkg::GraceMs : '0;
        end

        gesture = !n_armed
            && ({1'b0, i_raw.thr} + scc_pkg::GestureRaw < {1'b0, i_center.thr})
            && ({1'b0, i_raw.yaw} > {1'b0, i_center.yaw} + scc_pkg::GestureRaw)
            && ({1'b0, i_raw.pitch} + scc_pkg::GestureRaw < {1'b0, i_center.pitch})
            && ({1'b0, i_raw.roll} + scc_pkg::GestureRaw < {1'b0, i_center.roll});

        // a zero start stamp means no hold in progress
        hs_eff = (r_hold_start == '0) ? i_now : r_hold_start;
        hf_eff = (r_hold_start == '0) ? 1'b0 : r_hold_fired;
        if (gesture) begin
            n_hold_start = hs_eff;
            n_hold_fired = hf_eff || ((i_now - hs_eff) >= scc_pkg::HoldMs);
        end else begin
            n_hold_start = '0;
            n_hold_fired = 1'b0;
        end

        send        = (i_now - r_send_time) >= scc_pkg::SendMs;
        n_send_time = send ? i_now : r_send_time;

        o_status.armed = n_armed;
        o_status.grace = (n_grace_end != '0) && (i_now < n_grace_end);
        o_status.cal   = gesture && n_hold_fired;
        o_status.send  = send;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left   <= 1'b1;
            r_prev_right  <= 1'b1;
            r_armed       <= 1'b0;
            r_hold_fired  <= 1'b0;
            r_toggle_time <= '0;
            r_grace_end   <= '0;
            r_hold_start  <= '0;
            r_send_time   <= '0;
        end else if (i_adv) begin
            r_prev_left   <= i_left;
            r_prev_right  <= i_right;
            r_armed       <= n_armed;
            r_hold_fired  <= n_hold_fired;
            r_toggle_time <= n_toggle_time;
            r_grace_end   <= n_grace_end;
            r_hold_start  <= n_hold_start;
            r_send_time   <= n_send_time;
        end
    end

endmodule
`default_nettype wire

[rtl/scc_stick_map.sv]
// Deadband (yaw, pitch, roll), clamp and scaling of four stick readings to commands.
`default_nettype none
module scc_stick_map (
    input  scc_pkg::t_sticks                    i_raw,
    input  scc_pkg::t_sticks                    i_center,
    input  scc_pkg::t_mode_status               i_status,
    output logic [scc_pkg::CmdW-1:0]            o_thr_cmd,
    output logic signed [scc_pkg::CmdW-1:0]     o_yaw_cmd,
    output logic signed [scc_pkg::CmdW-1:0]     o_pitch_cmd,
    output logic signed [scc_pkg::CmdW-1:0]     o_roll_cmd
);

    function automatic logic [scc_pkg::CmdW-1:0] map_axis(
        input logic [scc_pkg::RawW-1:0] raw,
        input logic [scc_pkg::RawW-1:0] c,
        input logic                     invert
    );
        logic signed [scc_pkg::RawW:0] v;
        logic [scc_pkg::RawW:0]        mag;
        logic [scc_pkg::RawW-1:0]      m;
        logic [scc_pkg::CmdW-1:0]      q;
        logic                          neg;
        v   = $signed({1'b0, raw}) - $signed({1'b0, c});
        mag = v[scc_pkg::RawW] ? -v : v;
        m   = mag[scc_pkg::RawW-1:0];
        if (m < scc_pkg::Deadband) begin
            m = '0;
        end else if (m > scc_pkg::AxisSpan) begin
            m = scc_pkg::AxisSpan;
        end
        q   = scc_pkg::scale_5_18(m);
        neg = v[scc_pkg::RawW] ^ invert;
        return neg ? -q : q;
    endfunction

    logic signed [scc_pkg::RawW:0] thr_v, thr_w;
    logic [scc_pkg::RawW-1:0]      thr_span;
    logic                          thr_cut;

    always_comb begin
        thr_v = $signed({1'b0, i_raw.thr}) - $signed({1'b0, i_center.thr});
        thr_w = thr_v + $signed({1'b0, scc_pkg::AxisSpan});
        if (thr_v < -$signed({1'b0, scc_pkg::AxisSpan})) begin
            thr_span = '0;
        end else if (thr_v > $signed({1'b0, scc_pkg::AxisSpan})) begin
            thr_span = scc_pkg::ThrSpan;
        end else begin
            thr_span = thr_w[scc_pkg::RawW-1:0];
        end
        thr_cut = ({1'b0, i_raw.thr} + scc_pkg::ThrCut) < {1'b0, i_center.thr};

        if (thr_cut || !i_status.armed || i_status.grace) begin
            o_thr_cmd = '0;
        end else begin
            o_thr_cmd = scc_pkg::scale_5_18(thr_span);
        end

        o_yaw_cmd   = map_axis(i_raw.yaw, i_center.yaw, 1'b0);
        o_pitch_cmd = map_axis(i_raw.pitch, i_center.pitch, 1'b1);
        o_roll_cmd  = map_axis(i_raw.roll, i_center.roll, 1'b0);
    end

endmodule
`default_nettype wire

[rtl/stick_command_conditioner.sv]
// Top level: input register, mode state, stick mapping and result register.
//
// Stick command conditioner. One beat on the slave channel is one sample;
// it yields exactly one command beat on the master channel, in order.
// Slave tdata holds now_ms, left_button, right_button, then the throttle,
// yaw, pitch and roll samples. Master tdata holds armed_out, level_cal_cmd,
// throttle_cmd, yaw_cmd, pitch_cmd, roll_cmd and send_now.
// Centers are set through the write port (index 0..3: throttle, yaw, pitch,
// roll) and should only be changed while no beat is in flight.
// An accepted sample sits in the input register, is processed by the mode and
// mapping logic, and is loaded into the result register once that is empty or
// being taken, at which point m_axis_tvalid rises.
// Throughput: one sample per cycle while results are taken; the arm/hold/send
// state update is a combinational compare path from input to result register.
// If the master side stalls, the result register holds and the input
// register still fills, then s_axis_tready drops until the result is taken.
// Reset clears both valid flags, disarms, clears the hold and timers and
// returns every center to 2048.
`default_nettype none
module stick_command_conditioner (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [1:0]                      i_cfg_idx,
    input  wire [scc_pkg::RawW-1:0]        i_cfg_data,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] now_ms, [32] left_button, [33] right_button, [45:34] throttle_raw,
    // [57:46] yaw_raw, [69:58] pitch_raw, [81:70] roll_raw, [87:82] zero
    input  wire [scc_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [0] armed_out, [1] level_cal_cmd, [11:2] throttle_cmd, [21:12] yaw_cmd,
    // [31:22] pitch_cmd, [41:32] roll_cmd, [42] send_now, [47:43] zero
    output logic [scc_pkg::OutDataW-1:0]   m_axis_tdata
);

    scc_pkg::t_sticks          r_center;
    logic                      r_in_valid, r_out_valid;
    logic [81:0]               r_in_data;
    logic [42:0]               r_out_data;

    logic                      adv;
    scc_pkg::t_sticks          raw;
    scc_pkg::t_mode_status     status;
    logic [scc_pkg::CmdW-1:0]  thr_cmd, yaw_cmd, pitch_cmd, roll_cmd;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_data};

    assign raw.thr   = r_in_data[45:34];
    assign raw.yaw   = r_in_data[57:46];
    assign raw.pitch = r_in_data[69:58];
    assign raw.roll  = r_in_data[81:70];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center.thr   <= scc_pkg::CenterReset;
            r_center.yaw   <= scc_pkg::CenterReset;
            r_center.pitch <= scc_pkg::CenterReset;
            r_center.roll  <= scc_pkg::CenterReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                scc_pkg::RegThrCenter:   r_center.thr   <= i_cfg_data;
                scc_pkg::RegYawCenter:   r_center.yaw   <= i_cfg_data;
                scc_pkg::RegPitchCenter: r_center.pitch <= i_cfg_data;
                scc_pkg::RegRollCenter:  r_center.roll  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[81:0];
        end
        if (adv) begin
            r_out_data <= {status.send, roll_cmd, pitch_cmd, yaw_cmd, thr_cmd,
                           status.cal, status.armed};
        end
    end

    scc_mode u_mode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_now    (r_in_data[31:0]),
        .i_left   (r_in_data[32]),
        .i_right  (r_in_data[33]),
        .i_raw    (raw),
        .i_center (r_center),
        .o_status (status)
    );

    scc_stick_map u_map (
        .i_raw       (raw),
        .i_center    (r_center),
        .i_status    (status),
        .o_thr_cmd   (thr_cmd),
        .o_yaw_cmd   (yaw_cmd),
        .o_pitch_cmd (pitch_cmd),
        .o_roll_cmd  (roll_cmd)
    );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking stream testbench for the stick command conditioner.
module tb_top;

    localparam int          DeadbandV  = 40;
    localparam int          SpanV      = 1800;
    localparam int          AxisOutV   = 500;
    localparam int          ThrOutV    = 1000;
    localparam int          ThrCutV    = 120;
    localparam int          GestureV   = 900;
    localparam logic [31:0] LockoutMs  = 32'd250;
    localparam logic [31:0] GraceLenMs = 32'd300;
    localparam logic [31:0] HoldLenMs  = 32'd3000;
    localparam logic [31:0] SendGapMs  = 32'd20;
    localparam int          LongStall  = 300;

    typedef struct {
        logic [31:0]              now_ms;
        logic                     left_btn;
        logic                     right_btn;
        logic [scc_pkg::RawW-1:0] thr;
        logic [scc_pkg::RawW-1:0] yaw;
        logic [scc_pkg::RawW-1:0] pitch;
        logic [scc_pkg::RawW-1:0] roll;
    } t_stick_sample;

    typedef struct {
        logic                     armed;
        logic                     cal;
        logic [scc_pkg::CmdW-1:0] thr;
        logic [scc_pkg::CmdW-1:0] yaw;
        logic [scc_pkg::CmdW-1:0] pitch;
        logic [scc_pkg::CmdW-1:0] roll;
        logic                     send;
    } t_stick_cmd;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic [1:0]                   i_cfg_idx     = scc_pkg::RegThrCenter;
    logic [scc_pkg::RawW-1:0]     i_cfg_data    = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // [31:0] now_ms, [32] left_button, [33] right_button, [45:34] throttle_raw,
    // [57:46] yaw_raw, [69:58] pitch_raw, [81:70] roll_raw, [87:82] zero
    logic [scc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [0] armed_out, [1] level_cal_cmd, [11:2] throttle_cmd, [21:12] yaw_cmd,
    // [31:22] pitch_cmd, [41:32] roll_cmd, [42] send_now, [47:43] zero
    logic [scc_pkg::OutDataW-1:0] m_axis_tdata;

    stick_command_conditioner u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the centers and of the mode state
    int          ctr_thr = 2048, ctr_yaw = 2048, ctr_pitch = 2048, ctr_roll = 2048;
    logic        prev_l = 1'b1, prev_r = 1'b1, armed_st = 1'b0, hold_done = 1'b0;
    logic [31:0] toggle_t = '0, grace_end_t = '0, hold_t0 = '0, send_t = '0;

    t_stick_sample sample_q[$];
    t_stick_cmd    cmd_expect_q[$];
    t_stick_sample cur_sample;
    t_stick_cmd    drv_cmd, got_cmd, exp_cmd;

    int   n_queued = 0, n_accepted = 0, n_bad = 0, n_results = 0;
    int   src_gap = 0, sink_gap = 0, stall_left = 0;
    int   hold_req_cnt = 0, hold_seen_cnt = 0;
    bit   idle_on = 1'b1;
    logic [31:0] t_ms = '0;

    function automatic logic [scc_pkg::CmdW-1:0] map_axis(int raw, int ctr, bit invert);
        int v;
        int o;
        logic [31:0] w;
        v = raw - ctr;
        if (v > -DeadbandV && v < DeadbandV) v = 0;
        if (v < -SpanV) v = -SpanV;
        else if (v > SpanV) v = SpanV;
        o = v * AxisOutV / SpanV;
        if (invert) o = -o;
        if (o < -AxisOutV) o = -AxisOutV;
        else if (o > AxisOutV) o = AxisOutV;
        w = o;
        return w[scc_pkg::CmdW-1:0];
    endfunction

    function automatic logic [scc_pkg::CmdW-1:0] map_thr(int raw, int ctr);
        int v;
        int o;
        logic [31:0] w;
        v = raw - ctr;
        if (v < -SpanV) v = -SpanV;
        else if (v > SpanV) v = SpanV;
        o = (v + SpanV) * ThrOutV / (2 * SpanV);
        if (o < 0) o = 0;
        else if (o > ThrOutV) o = ThrOutV;
        if (raw < ctr - ThrCutV) o = 0;
        w = o;
        return w[scc_pkg::CmdW-1:0];
    endfunction

    // advances the shadow state by one sample
    function automatic t_stick_cmd predict_cmd(t_stick_sample s);
        t_stick_cmd  c;
        logic        fell;
        logic        gest;
        logic [31:0] dt;
        int          a_thr, a_yaw, a_pitch, a_roll;
        a_thr   = s.thr;
        a_yaw   = s.yaw;
        a_pitch = s.pitch;
        a_roll  = s.roll;
        fell = (prev_l && !s.left_btn) || (prev_r && !s.right_btn);
        dt = s.now_ms - toggle_t;
        if (fell && dt > LockoutMs) begin
            armed_st    = !armed_st;
            toggle_t    = s.now_ms;
            grace_end_t = armed_st ? s.now_ms + GraceLenMs : 32'd0;
        end
        prev_l = s.left_btn;
        prev_r = s.right_btn;

        gest = !armed_st && a_thr < ctr_thr - GestureV && a_yaw > ctr_yaw + GestureV &&
               a_pitch < ctr_pitch - GestureV && a_roll < ctr_roll - GestureV;
        if (gest) begin
            // a hold that started at time zero reads as no hold
            if (hold_t0 == 32'd0) begin
                hold_t0   = s.now_ms;
                hold_done = 1'b0;
            end
            dt = s.now_ms - hold_t0;
            if (!hold_done && dt >= HoldLenMs) hold_done = 1'b1;
            c.cal = hold_done;
        end else begin
            hold_t0   = '0;
            hold_done = 1'b0;
            c.cal     = 1'b0;
        end

        c.thr = map_thr(a_thr, ctr_thr);
        if (!armed_st || (grace_end_t != 32'd0 && s.now_ms < grace_end_t)) c.thr = '0;

        dt = s.now_ms - send_t;
        if (dt >= SendGapMs) begin
            send_t = s.now_ms;
            c.send = 1'b1;
        end else begin
            c.send = 1'b0;
        end

        c.armed = armed_st;
        c.yaw   = map_axis(a_yaw, ctr_yaw, 1'b0);
        c.pitch = map_axis(a_pitch, ctr_pitch, 1'b1);
        c.roll  = map_axis(a_roll, ctr_roll, 1'b0);
        return c;
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drv_cmd = predict_cmd(cur_sample);
                cmd_expect_q.push_back(drv_cmd);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur_sample = sample_q.pop_front();
                    s_axis_tdata <= {6'd0, cur_sample.roll, cur_sample.pitch, cur_sample.yaw,
                                     cur_sample.thr, cur_sample.right_btn, cur_sample.left_btn,
                                     cur_sample.now_ms};
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got_cmd.armed = m_axis_tdata[0];
                got_cmd.cal   = m_axis_tdata[1];
                got_cmd.thr   = m_axis_tdata[11:2];
                got_cmd.yaw   = m_axis_tdata[21:12];
                got_cmd.pitch = m_axis_tdata[31:22];
                got_cmd.roll  = m_axis_tdata[41:32];
                got_cmd.send  = m_axis_tdata[42];
                if (cmd_expect_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("result %0d: no command expected", n_results);
                end else begin
                    exp_cmd = cmd_expect_q.pop_front();
                    if (got_cmd.armed !== exp_cmd.armed || got_cmd.cal !== exp_cmd.cal ||
                        got_cmd.thr !== exp_cmd.thr || got_cmd.yaw !== exp_cmd.yaw ||
                        got_cmd.pitch !== exp_cmd.pitch || got_cmd.roll !== exp_cmd.roll ||
                        got_cmd.send !== exp_cmd.send) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"result %0d: exp armed=%0d cal=%0d thr=%0d yaw=%0d ",
                                      "pitch=%0d roll=%0d send=%0d | got armed=%0d cal=%0d ",
                                      "thr=%0d yaw=%0d pitch=%0d roll=%0d send=%0d"},
                                     n_results, exp_cmd.armed, exp_cmd.cal, exp_cmd.thr,
                                     $signed(exp_cmd.yaw), $signed(exp_cmd.pitch),
                                     $signed(exp_cmd.roll), exp_cmd.send,
                                     got_cmd.armed, got_cmd.cal, got_cmd.thr,
                                     $signed(got_cmd.yaw), $signed(got_cmd.pitch),
                                     $signed(got_cmd.roll), got_cmd.send);
                    end
                end
            end
            if (hold_req_cnt != hold_seen_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                stall_left = LongStall;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 10);
            end
        end
    end

    task automatic add_sample(input logic [31:0] now, input bit lb, input bit rb,
                              input int thr, input int yaw, input int pitch, input int roll);
        t_stick_sample s;
        s.now_ms    = now;
        s.left_btn  = lb;
        s.right_btn = rb;
        s.thr       = thr[scc_pkg::RawW-1:0];
        s.yaw       = yaw[scc_pkg::RawW-1:0];
        s.pitch     = pitch[scc_pkg::RawW-1:0];
        s.roll      = roll[scc_pkg::RawW-1:0];
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic write_center(input logic [1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[scc_pkg::RawW-1:0];
        case (idx)
            scc_pkg::RegThrCenter:   ctr_thr   = val;
            scc_pkg::RegYawCenter:   ctr_yaw   = val;
            scc_pkg::RegPitchCenter: ctr_pitch = val;
            scc_pkg::RegRollCenter:  ctr_roll  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || cmd_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int clip_raw(int v);
        return v < 0 ? 0 : (v > 4095 ? 4095 : v);
    endfunction

    // stick value around a center, weighted toward the mapping boundaries
    function automatic int near(int ctr);
        int v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 4095);
            1: v = ctr + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(39, 40));
            2: v = ctr - int'($urandom_range(120, 121));
            3: v = ctr + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1799, 1801));
            4: v = $urandom_range(0, 1) ? 4095 : 0;
            default: v = ctr + int'($urandom_range(0, 600)) - 300;
        endcase
        return clip_raw(v);
    endfunction

    function automatic int gest_lo(int ctr);
        if (ctr - GestureV - 1 < 0) return $urandom_range(0, 4095);
        if ($urandom_range(0, 15) == 0) return ctr - GestureV;
        return $urandom_range(0, ctr - GestureV - 1);
    endfunction

    function automatic int gest_hi(int ctr);
        if (ctr + GestureV + 1 > 4095) return $urandom_range(0, 4095);
        if ($urandom_range(0, 15) == 0) return ctr + GestureV;
        return $urandom_range(ctr + GestureV + 1, 4095);
    endfunction

    task automatic gen_random(input int n);
        int target;
        int len;
        target = n_queued + n;
        while (n_queued < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(10, 40);
                    repeat (len) begin
                        if ($urandom_range(0, 9) == 0) t_ms += $urandom_range(200, 400);
                        else t_ms += $urandom_range(0, 40);
                        add_sample(t_ms, $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0,
                                   near(ctr_thr), near(ctr_yaw), near(ctr_pitch),
                                   near(ctr_roll));
                    end
                end
                6, 7: begin
                    // calibration gesture held long enough to fire most of the time
                    if ($urandom_range(0, 1)) begin
                        t_ms += 300;
                        add_sample(t_ms, 1'b0, 1'b1, near(ctr_thr), near(ctr_yaw),
                                   near(ctr_pitch), near(ctr_roll));
                    end
                    len = $urandom_range(30, 60);
                    repeat (len) begin
                        t_ms += $urandom_range(40, 120);
                        add_sample(t_ms, 1'b1, 1'b1, gest_lo(ctr_thr), gest_hi(ctr_yaw),
                                   gest_lo(ctr_pitch), gest_lo(ctr_roll));
                    end
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                    len = $urandom_range(1, 5);
                    repeat (len)
                        add_sample($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095));
                end
            endcase
        end
    endtask

    task automatic run_directed();
        // hold starting at time zero, reset lockout, hold firing after 3000 ms
        add_sample(32'd0,    1, 1,    0, 4095,    0,    0);
        add_sample(32'd10,   0, 1,    0, 4095,    0,    0);
        add_sample(32'd20,   1, 1,    0, 4095,    0,    0);
        add_sample(32'd3009, 1, 1,    0, 4095,    0,    0);
        add_sample(32'd3010, 1, 1,    0, 4095,    0,    0);
        add_sample(32'd3020, 1, 1,    0, 4095,    0,    0);
        add_sample(32'd3030, 1, 1, 4095, 4095, 4095, 4095);
        add_sample(32'd3040, 1, 1, 2048, 2048, 2048, 2048);
        // arm, grace window, deadband and throttle cut edges, disarm
        add_sample(32'd3100, 0, 1, 4095, 2048, 2048, 2048);
        add_sample(32'd3399, 0, 1, 4095, 2048, 2048, 2048);
        add_sample(32'd3400, 0, 1, 4095, 2048, 2048, 2048);
        add_sample(32'd3410, 0, 1, 1928, 2087, 2009, 2088);
        add_sample(32'd3420, 0, 1, 1927, 2008, 2088, 2008);
        add_sample(32'd3430, 0, 0, 4095, 4095,    0, 4095);
        add_sample(32'd3440, 1, 1, 4095,    0, 4095,    0);
        add_sample(32'd3500, 1, 0, 4095, 2048, 2048, 2048);
        add_sample(32'd3510, 1, 1, 4095, 2048, 2048, 2048);
        // arming where the grace end wraps to zero, then time wrap
        add_sample(32'hFFFF_FED4, 0, 1, 4095, 2048, 2048, 2048);
        add_sample(32'hFFFF_FEE0, 0, 1, 4095, 2048, 2048, 2048);
        add_sample(32'h0000_0005, 1, 1,    0, 4095,    0,    0);
        t_ms = 32'd5;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        gen_random(150);
        wait_drained();

        write_center(scc_pkg::RegThrCenter, 4095);
        write_center(scc_pkg::RegYawCenter, 4095);
        write_center(scc_pkg::RegPitchCenter, 4095);
        write_center(scc_pkg::RegRollCenter, 4095);
        gen_random(220);
        wait_drained();

        write_center(scc_pkg::RegThrCenter, 0);
        write_center(scc_pkg::RegYawCenter, 0);
        write_center(scc_pkg::RegPitchCenter, 0);
        write_center(scc_pkg::RegRollCenter, 0);
        gen_random(220);
        wait_drained();

        write_center(scc_pkg::RegThrCenter, $urandom_range(1000, 3000));
        write_center(scc_pkg::RegYawCenter, $urandom_range(1000, 3000));
        write_center(scc_pkg::RegPitchCenter, $urandom_range(1000, 3000));
        write_center(scc_pkg::RegRollCenter, $urandom_range(1000, 3000));
        hold_req_cnt++;
        gen_random(300);
        wait_drained();

        write_center(scc_pkg::RegThrCenter, $urandom_range(0, 4095));
        write_center(scc_pkg::RegYawCenter, $urandom_range(0, 4095));
        write_center(scc_pkg::RegPitchCenter, $urandom_range(0, 4095));
        write_center(scc_pkg::RegRollCenter, $urandom_range(0, 4095));
        gen_random(300);
        wait_drained();

        // back to rest centers, full rate on both sides
        idle_on = 1'b0;
        write_center(scc_pkg::RegThrCenter, 2048);
        write_center(scc_pkg::RegYawCenter, 2048);
        write_center(scc_pkg::RegPitchCenter, 2048);
        write_center(scc_pkg::RegRollCenter, 2048);
        gen_random(300);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (n_bad == 0 && cmd_expect_q.size() == 0) begin
            $display("stick_command_conditioner: match");
        end else begin
            $display("stick_command_conditioner: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("stick_command_conditioner: mismatch");
        $finish;
    end

endmodule
